// File: rtl/stable_min_priority_queue_macros.svh
// Assertion macros used by the queue's top-level RTL file.
// Every check runs on the rising edge of clk and is off while rst_n is low.
`ifndef STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SMPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smpq: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SMPQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smpq: next-cycle check failed");

`endif

// File: rtl/smpq_pkg.sv
package smpq_pkg;

  // Default number of entries the queue can hold.
  localparam int CAPACITY_DEF = 16;

  // Depth of the command queue between the front and the back.
  localparam int FIFO_DEPTH = 2;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  // Operation codes on the input channel.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // What the back has to do with a command.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2
  } cmd_kind_t;

  // One classified command travelling from the front to the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  status;
    logic [31:0] tag;
    logic [31:0] key;
  } cmd_t;

  // One stored entry of the sorted array.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] key;
  } entry_t;

  // Sort key: biased priority on top, tiebreak below; unsigned compare orders it.
  function automatic logic [31:0] make_key(input logic [15:0] prio, input logic [15:0] order);
    logic [15:0] biased;
    biased = prio ^ 16'h8000;
    return {biased, order};
  endfunction

endpackage

// File: rtl/smpq_front.sv
module smpq_front #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               in_func,
  input  logic [31:0]        in_push_tag,
  input  logic signed [15:0] in_push_priority,
  input  logic [15:0]        in_push_order,
  output logic               cmd_wr,
  output smpq_pkg::cmd_t     cmd_out,
  output logic [CNT_W-1:0]   shadow_count
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  smpq_pkg::cmd_t   cmd;

  // Classify the accepted beat against the projected fill level.
  always_comb begin
    count_nxt   = count_r;
    cmd.kind    = smpq_pkg::CMD_HOLD;
    cmd.status  = smpq_pkg::ST_OK;
    cmd.tag     = in_push_tag;
    cmd.key     = smpq_pkg::make_key(in_push_priority, in_push_order);
    case (in_func)
      smpq_pkg::FUNC_PUSH: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          cmd.status = smpq_pkg::ST_PUSH_FULL;
        end else begin
          cmd.kind  = smpq_pkg::CMD_PUSH;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      smpq_pkg::FUNC_POP: begin
        if (count_r == '0) begin
          cmd.status = smpq_pkg::ST_POP_EMPTY;
        end else begin
          cmd.kind  = smpq_pkg::CMD_POP;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        cmd.kind = smpq_pkg::CMD_HOLD;
      end
    endcase
  end

  // The projected count is updated on every accepted beat; a push on full or a pop on empty leaves it unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  assign cmd_wr       = accept;
  assign cmd_out      = cmd;
  assign shadow_count = count_r;

endmodule

// File: rtl/smpq_cmd_fifo.sv
module smpq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  smpq_pkg::cmd_t wr_data,
  input  logic           rd,
  output smpq_pkg::cmd_t rd_data,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (smpq_pkg::FIFO_DEPTH > 1) ? $clog2(smpq_pkg::FIFO_DEPTH) : 1;
  localparam int OCC_W = $clog2(smpq_pkg::FIFO_DEPTH + 1);

  smpq_pkg::cmd_t   q_r [smpq_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [OCC_W-1:0] occ_r;
  logic             do_wr;
  logic             do_rd;

  assign empty = (occ_r == '0);
  assign full  = (occ_r == OCC_W'(smpq_pkg::FIFO_DEPTH));
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = q_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(smpq_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(smpq_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        occ_r <= occ_r + OCC_W'(1);
      end else if (do_rd && !do_wr) begin
        occ_r <= occ_r - OCC_W'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/smpq_back.sv
module smpq_back #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  smpq_pkg::cmd_t   cmd,
  output logic             out_strobe,
  output logic [31:0]      out_head_tag,
  output logic             out_head_valid,
  output logic [4:0]       out_fill_count,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] count
);

  smpq_pkg::entry_t  store_r   [CAPACITY];
  smpq_pkg::entry_t  store_nxt [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W+4:0]  cnt_ext;
  logic              strobe_r;
  logic [31:0]       head_tag_r;
  logic              head_valid_r;
  logic [4:0]        fill_r;
  logic [1:0]        status_r;
  smpq_pkg::entry_t  new_entry;

  assign new_entry.tag = cmd.tag;
  assign new_entry.key = cmd.key;

  // Each cell sorts itself: shift down behind a larger key, take the new
  // entry at the boundary, or move up on a pop.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             prev_gt;
    logic             at_end;
    smpq_pkg::entry_t prev_e;
    smpq_pkg::entry_t next_e;

    assign gt[g]  = (CNT_W'(g) < count_r) && (store_r[g].key > cmd.key);
    assign at_end = (CNT_W'(g) == count_r);

    if (g == 0) begin : g_first
      assign prev_gt = 1'b0;
      assign prev_e  = store_r[g];
    end else begin : g_rest
      assign prev_gt = gt[g-1];
      assign prev_e  = store_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_e = store_r[g];
    end else begin : g_inner
      assign next_e = store_r[g+1];
    end

    always_comb begin
      store_nxt[g] = store_r[g];
      case (cmd.kind)
        smpq_pkg::CMD_PUSH: begin
          if (prev_gt) begin
            store_nxt[g] = prev_e;
          end else if (gt[g] || at_end) begin
            store_nxt[g] = new_entry;
          end
        end
        smpq_pkg::CMD_POP: begin
          store_nxt[g] = next_e;
        end
        default: begin
          store_nxt[g] = store_r[g];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (cmd_valid) begin
        store_r[g] <= store_nxt[g];
      end
    end
  end

  // Entry count after the command.
  always_comb begin
    case (cmd.kind)
      smpq_pkg::CMD_PUSH: count_nxt = count_r + CNT_W'(1);
      smpq_pkg::CMD_POP:  count_nxt = count_r - CNT_W'(1);
      default:            count_nxt = count_r;
    endcase
  end

  assign cnt_ext = {5'd0, count_nxt};

  // Count register and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd_valid;
      if (cmd_valid) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result beat, built from the post-operation head.
  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      head_valid_r <= (count_nxt != '0);
      head_tag_r   <= (count_nxt != '0) ? store_nxt[0].tag : 32'd0;
      fill_r       <= cnt_ext[4:0];
      status_r     <= cmd.status;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_head_tag   = head_tag_r;
  assign out_head_valid = head_valid_r;
  assign out_fill_count = fill_r;
  assign out_status     = status_r;
  assign count          = count_r;

endmodule

// File: rtl/stable_min_priority_queue.sv
// Stable bounded min-priority queue of tagged events.
// Input: raise start with in_func (0 push, 1 pop) and the push fields; the
// beat is taken at a rising edge where start is high and busy is low. Push
// fields are ignored on a pop.
// Output: every beat gives one result on the out_ ports for exactly one
// cycle, marked by out_strobe: the head tag after the operation (zero when
// empty), a non-empty flag, the fill count and a status (ok, pop on empty,
// push on full). The receiver cannot stall; results are never held.
// An accepted beat passes the command queue and then the result register
// before out_strobe rises. The front classifies and enqueues a command at
// the accepting edge; the back applies it to the sorted register array at
// the next edge, one command per cycle, so one beat per cycle is sustained
// and busy only rises in reset.
// Reset (rst_n low, synchronous) empties the queue; no stored entry is
// cleared, since entries beyond the fill count are never read.
// Equal priority and tiebreak keep arrival order.
`include "stable_min_priority_queue_macros.svh"

module stable_min_priority_queue #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [31:0]        in_push_tag,
  input  logic signed [15:0] in_push_priority,
  input  logic [15:0]        in_push_order,
  output logic               out_strobe,
  output logic [31:0]        out_head_tag,
  output logic               out_head_valid,
  output logic [4:0]         out_fill_count,
  output logic [1:0]         out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             accept;
  logic             cmd_wr;
  smpq_pkg::cmd_t   cmd_in;
  smpq_pkg::cmd_t   cmd_head;
  logic             fifo_empty;
  logic             fifo_full;
  logic [CNT_W-1:0] shadow_count;
  logic [CNT_W-1:0] back_count;

  assign busy   = fifo_full || !rst_n;
  assign accept = start && !busy;

  // Front: accept and classify.
  smpq_front #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_func          (in_func),
    .in_push_tag      (in_push_tag),
    .in_push_priority (in_push_priority),
    .in_push_order    (in_push_order),
    .cmd_wr           (cmd_wr),
    .cmd_out          (cmd_in),
    .shadow_count     (shadow_count)
  );

  // Command queue between front and back.
  smpq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_wr),
    .wr_data (cmd_in),
    .rd      (!fifo_empty),
    .rd_data (cmd_head),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  // Back: sorted store and result register.
  smpq_back #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (!fifo_empty),
    .cmd            (cmd_head),
    .out_strobe     (out_strobe),
    .out_head_tag   (out_head_tag),
    .out_head_valid (out_head_valid),
    .out_fill_count (out_fill_count),
    .out_status     (out_status),
    .count          (back_count)
  );

  // With nothing in flight, the front's projection matches the store.
  `SMPQ_ASSERT_IMP(a_count_track, fifo_empty, shadow_count == back_count)
  // Every result beat comes from an earlier accepted beat.
  `SMPQ_ASSERT_IMP(a_latency, out_strobe, $past(accept, 2))
  // An ignored pop leaves the queue empty.
  `SMPQ_ASSERT_IMP(a_empty_pop, out_strobe && (out_status == smpq_pkg::ST_POP_EMPTY), !out_head_valid)
  // A command taken by the back always yields a strobe next cycle.
  `SMPQ_ASSERT_NXT(a_back_strobe, !fifo_empty, out_strobe)

endmodule

// File: tb/stable_min_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_min_priority_queue_tb;

  localparam int QCAP        = smpq_pkg::CAPACITY_DEF;
  localparam int STALL_LIMIT = 200;
  localparam int RAND_BEATS  = 1230;
  localparam int SETTLE      = 8;

  // One queued event as the predictor keeps it.
  typedef struct packed {
    logic [31:0]        tag;
    logic signed [15:0] prio;
    logic [15:0]        order;
  } event_entry_t;

  // What one result beat reports about the queue.
  typedef struct packed {
    logic [31:0] head_tag;
    logic        head_valid;
    logic [4:0]  fill_count;
    logic [1:0]  status;
  } queue_view_t;

  // One row of the directed stimulus; typed rows carry their own expectation.
  typedef struct packed {
    logic               func;
    logic [31:0]        tag;
    logic signed [15:0] prio;
    logic [15:0]        order;
    logic               typed;
    queue_view_t        view;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_func;
  logic [31:0]        in_push_tag;
  logic signed [15:0] in_push_priority;
  logic [15:0]        in_push_order;
  logic               out_strobe;
  logic [31:0]        out_head_tag;
  logic               out_head_valid;
  logic [4:0]         out_fill_count;
  logic [1:0]         out_status;

  // Predictor state: entries sorted from top to bottom.
  event_entry_t queue_model [QCAP];
  int           model_count = 0;

  queue_view_t  expected_views [$];
  stim_row_t    dir_rows [$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           idling_on = 1'b1;
  bit           row_typed = 1'b0;
  queue_view_t  row_view = '0;

  stable_min_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_push_tag      (in_push_tag),
    .in_push_priority (in_push_priority),
    .in_push_order    (in_push_order),
    .out_strobe       (out_strobe),
    .out_head_tag     (out_head_tag),
    .out_head_valid   (out_head_valid),
    .out_fill_count   (out_fill_count),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one row to the directed stimulus table.
  function automatic void add_row(input stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Apply one operation to the predictor and report the queue after it.
  task automatic apply_queue_op(input logic func, input logic [31:0] tag,
                                input logic signed [15:0] prio,
                                input logic [15:0] order,
                                output queue_view_t view);
    int slot;
    view.status = smpq_pkg::ST_OK;
    if (func == smpq_pkg::FUNC_PUSH) begin
      if (model_count >= QCAP) begin
        view.status = smpq_pkg::ST_PUSH_FULL;
      end else begin
        // A new entry only passes entries that it strictly beats, which
        // keeps arrival order on full ties.
        slot = 0;
        while (slot < model_count &&
               !($signed(prio) < $signed(queue_model[slot].prio) ||
                 ($signed(prio) == $signed(queue_model[slot].prio) &&
                  order < queue_model[slot].order)))
          slot++;
        for (int i = model_count; i > slot; i--)
          queue_model[i] = queue_model[i - 1];
        queue_model[slot] = '{tag, prio, order};
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        view.status = smpq_pkg::ST_POP_EMPTY;
      end else begin
        for (int i = 1; i < model_count; i++)
          queue_model[i - 1] = queue_model[i];
        model_count--;
      end
    end
    view.head_valid = (model_count != 0);
    view.head_tag   = (model_count != 0) ? queue_model[0].tag : 32'h0;
    view.fill_count = model_count[4:0];
  endtask

  // Take accepted beats into the predictor and check every result beat.
  always @(posedge clk) begin
    queue_view_t predicted;
    queue_view_t want;
    bit          took;
    if (rst_n) begin
      took = start && !busy;
      if (took) begin
        apply_queue_op(in_func, in_push_tag, in_push_priority, in_push_order, predicted);
        expected_views.insert(expected_views.size(), row_typed ? row_view : predicted);
      end
      if (out_strobe) begin
        if (expected_views.size() == 0) begin
          $error("result beat with nothing pending: head_tag %h", out_head_tag);
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          if (out_head_tag !== want.head_tag) begin
            $error("head_tag: expected %h, got %h", want.head_tag, out_head_tag);
            mismatch_count++;
          end
          if (out_head_valid !== want.head_valid) begin
            $error("head_valid: expected %b, got %b", want.head_valid, out_head_valid);
            mismatch_count++;
          end
          if (out_fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, out_fill_count);
            mismatch_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
        end
      end
      // Watchdog on cycles where neither channel moves a beat.
      quiet_cycles = (took || out_strobe) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // When idling is on, sometimes hold start low for a random gap, with the fields left as noise.
  task automatic maybe_idle();
    int gap;
    if (idling_on && $urandom_range(0, 99) < 24) begin
      gap = $urandom_range(1, 2);
      repeat (gap) begin
        start            <= 1'b0;
        in_func          <= 1'($urandom_range(0, 1));
        in_push_tag      <= $urandom();
        in_push_priority <= 16'($urandom());
        in_push_order    <= 16'($urandom());
        @(negedge clk);
      end
    end
  endtask

  // Present one beat and wait until the queue takes it.
  task automatic send_beat(input logic func, input logic [31:0] tag,
                           input logic signed [15:0] prio, input logic [15:0] order);
    maybe_idle();
    start            <= 1'b1;
    in_func          <= func;
    in_push_tag      <= tag;
    in_push_priority <= prio;
    in_push_order    <= order;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (expected_views.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic               func;
    logic signed [15:0] prio;
    logic [15:0]        order;
    int                 push_pct;

    start            <= 1'b0;
    in_func          <= smpq_pkg::FUNC_PUSH;
    in_push_tag      <= 32'h0;
    in_push_priority <= 16'sh0;
    in_push_order    <= 16'h0;
    rst_n            <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: an empty pop, field extremes, full ties, then fill to
    // capacity, push onto the full queue, then pop and push once more.
    add_row('{smpq_pkg::FUNC_POP,  32'h0,        16'sh0,    16'h0,    1'b1,
              '{32'h0, 1'b0, 5'd0, smpq_pkg::ST_POP_EMPTY}});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hFFFFFFFF, 16'sh7FFF, 16'hFFFF, 1'b1,
              '{32'hFFFFFFFF, 1'b1, 5'd1, smpq_pkg::ST_OK}});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h00000000, 16'sh8000, 16'h0000, 1'b1,
              '{32'h0, 1'b1, 5'd2, smpq_pkg::ST_OK}});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hA5A5A5A5, 16'sh8000, 16'h0000, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h5A5A5A5A, 16'sh0000, 16'h0001, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h00000001, 16'sh0000, 16'h0000, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h00000002, 16'shFFFF, 16'hFFFF, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_POP,  32'hDEADBEEF, 16'sh8000, 16'h0000, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h80000000, 16'sh7FFF, 16'h0000, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h00000003, 16'sh0000, 16'h0000, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h0000FFFF, 16'sh0001, 16'h8000, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hFFFF0000, 16'sh0001, 16'h7FFF, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h12345678, 16'sh4000, 16'h1234, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h00000004, 16'sh7FFF, 16'hFFFF, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h55555555, 16'sh0002, 16'h0002, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hAAAAAAAA, 16'sh0002, 16'h0001, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h0F0F0F0F, 16'sh3FFF, 16'hFFFE, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hF0F0F0F0, 16'sh0000, 16'hFFFF, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'h33333333, 16'sh0002, 16'h0002, 1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hCCCCCCCC, 16'sh8000, 16'hFFFF, 1'b1,
              '{32'hA5A5A5A5, 1'b1, 5'd16, smpq_pkg::ST_PUSH_FULL}});
    add_row('{smpq_pkg::FUNC_POP,  32'h0,        16'sh0,    16'h0,    1'b0, '0});
    add_row('{smpq_pkg::FUNC_PUSH, 32'hC3C3C3C3, 16'sh8000, 16'h0000, 1'b0, '0});
    foreach (dir_rows[r]) begin
      row_typed = dir_rows[r].typed;
      row_view  = dir_rows[r].view;
      send_beat(dir_rows[r].func, dir_rows[r].tag, dir_rows[r].prio, dir_rows[r].order);
    end
    row_typed = 1'b0;
    drain_results();

    // Random part: blocks that lean toward filling, draining or balance,
    // with many priority and tiebreak collisions.
    push_pct = 50;
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 55;
        endcase
      end
      if (n > 0 && n % 250 == 0)
        drain_results();
      idling_on = !(n >= 400 && n < 700);
      func = ($urandom_range(0, 99) < push_pct) ? smpq_pkg::FUNC_PUSH : smpq_pkg::FUNC_POP;
      case ($urandom_range(0, 3))
        0: prio = 16'($urandom());
        1: prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: prio = $signed(16'($urandom_range(0, 6))) - 16'sd3;
      endcase
      order = $urandom_range(0, 2) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3));
      send_beat(func, $urandom(), prio, order);
    end
    idling_on = 1'b1;

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
